// ===== rtl/core/ufdr_pkg.sv =====
// Shared types and constants for the UART FIFO data register unit.
package ufdr_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 32;
  localparam int LEVEL_W = 6;

  typedef enum logic [1:0] {
    ACT_LINE_RX = 2'd0,
    ACT_CPU_READ = 2'd1,
    ACT_CPU_WRITE = 2'd2,
    ACT_FLUSH = 2'd3
  } action_t;

  typedef struct packed {
    logic overrun;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic push;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/ufdr_ifs.sv =====
// Channel interfaces for the UART FIFO data register unit.
interface ufdr_item_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface ufdr_result_if;
  logic valid;
  logic ready;
  logic [7:0] read_data;
  logic read_overrun;
  logic rx_empty;
  logic rx_full;
  logic tx_empty;
  logic tx_full;
  logic [5:0] rx_level;
  logic [5:0] tx_level;

  modport source (
    output valid, output read_data, output read_overrun, output rx_empty,
    output rx_full, output tx_empty, output tx_full, output rx_level,
    output tx_level, input ready
  );
  modport sink (
    input valid, input read_data, input read_overrun, input rx_empty,
    input rx_full, input tx_empty, input tx_full, input rx_level,
    input tx_level, output ready
  );
endinterface

interface ufdr_cfg_if;
  logic valid;
  logic ready;
  logic loopback_enable;

  modport source (output valid, output loopback_enable, input ready);
  modport sink (input valid, input loopback_enable, output ready);
endinterface

// ===== rtl/core/ufdr_cell.sv =====
// One receive FIFO slot that shifts toward the head or loads a pushed entry.
module ufdr_cell (
  input  logic                clk,
  input  ufdr_pkg::cell_ctrl_t ctrl,
  input  logic                is_tail,
  input  ufdr_pkg::entry_t    upper,
  output ufdr_pkg::entry_t    entry
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= upper;
    end else if (ctrl.push && is_tail) begin
      entry <= ctrl.new_entry;
    end
  end

endmodule

// ===== rtl/core/ufdr_rx_chain.sv =====
// Row of receive FIFO cells with the head entry at cell zero.
module ufdr_rx_chain #(
  parameter int FIFO_DEPTH = ufdr_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic                                clk,
  input  ufdr_pkg::cell_ctrl_t                ctrl,
  input  logic [$clog2(FIFO_DEPTH + 2)-1:0]   count,
  output ufdr_pkg::entry_t                    head
);

  localparam int SLOTS = FIFO_DEPTH + 1;
  localparam int CW = $clog2(FIFO_DEPTH + 2);

  ufdr_pkg::entry_t cells [SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ufdr_pkg::entry_t upper;
    logic is_tail;

    if (i == SLOTS - 1) begin : g_last
      assign upper = ctrl.new_entry;
    end else begin : g_mid
      assign upper = cells[i + 1];
    end

    assign is_tail = (count == CW'(i));

    ufdr_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .is_tail (is_tail),
      .upper   (upper),
      .entry   (cells[i])
    );
  end

  assign head = cells[0];

endmodule

// ===== rtl/core/uart_fifo_data_register_unit.sv =====
// Top level of the UART FIFO data register unit.
//
//   Channel  Dir  Handshake      Payload
//   item     in   valid/ready    action, data_byte
//   result   out  valid/ready    read_data, read_overrun, flags, levels
//   cfg      in   valid/ready    loopback_enable
//
// Each transfer on item yields one result in the next cycle.
// The receive FIFO is a row of cells that all shift toward the head on a read.
// Item ready stays high outside reset while the result register is empty or being taken.
// Reset clears the counts, the holding register and the loopback bit.
module uart_fifo_data_register_unit #(
  parameter int FIFO_DEPTH = ufdr_pkg::DEFAULT_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  ufdr_item_if.sink      item,
  ufdr_result_if.source  result,
  ufdr_cfg_if.sink       cfg
);

  localparam int SLOTS = FIFO_DEPTH + 1;
  localparam int CW = $clog2(FIFO_DEPTH + 2);
  localparam int TW = $clog2(FIFO_DEPTH + 1);
  localparam int LW = ufdr_pkg::LEVEL_W;

  logic [CW-1:0] rx_count;
  logic [CW-1:0] rx_count_next;
  logic [TW-1:0] tx_count;
  logic [TW-1:0] tx_count_next;
  logic [7:0] holding_data;
  logic holding_overrun;
  logic loopback;
  logic res_valid;

  logic accept;
  logic do_push;
  logic do_pop;
  logic do_tx;
  logic do_flush;
  ufdr_pkg::action_t act;
  ufdr_pkg::cell_ctrl_t ctrl;
  ufdr_pkg::entry_t head;
  logic [CW+LW-1:0] rx_ext;
  logic [TW+LW-1:0] tx_ext;

  assign act = ufdr_pkg::action_t'(item.action);
  assign item.ready = !rst && (!res_valid || result.ready);
  assign accept = item.valid && item.ready;
  assign cfg.ready = !rst;

  always_comb begin
    do_push = 1'b0;
    do_pop = 1'b0;
    do_tx = 1'b0;
    do_flush = 1'b0;
    unique case (act)
      ufdr_pkg::ACT_LINE_RX: do_push = rx_count != CW'(SLOTS);
      ufdr_pkg::ACT_CPU_READ: do_pop = rx_count != '0;
      ufdr_pkg::ACT_CPU_WRITE: begin
        do_push = loopback && (rx_count != CW'(SLOTS));
        do_tx = !loopback && (tx_count != TW'(FIFO_DEPTH));
      end
      ufdr_pkg::ACT_FLUSH: do_flush = 1'b1;
      default: ;
    endcase
  end

  assign ctrl.shift = accept && do_pop;
  assign ctrl.push = accept && do_push;
  assign ctrl.new_entry.overrun = rx_count == CW'(FIFO_DEPTH);
  assign ctrl.new_entry.data = item.data_byte;

  ufdr_rx_chain #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_rx_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (rx_count),
    .head  (head)
  );

  always_comb begin
    rx_count_next = rx_count;
    tx_count_next = tx_count;
    if (accept) begin
      priority if (do_flush) begin
        rx_count_next = '0;
        tx_count_next = '0;
      end else if (do_push) begin
        rx_count_next = rx_count + CW'(1);
      end else if (do_pop) begin
        rx_count_next = rx_count - CW'(1);
      end else if (do_tx) begin
        tx_count_next = tx_count + TW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
      tx_count <= '0;
      holding_data <= '0;
      holding_overrun <= 1'b0;
      loopback <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rx_count <= rx_count_next;
      tx_count <= tx_count_next;
      if (ctrl.shift) begin
        holding_data <= head.data;
        holding_overrun <= head.overrun;
      end
      if (cfg.valid) begin
        loopback <= cfg.loopback_enable;
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign rx_ext = {{LW{1'b0}}, rx_count};
  assign tx_ext = {{LW{1'b0}}, tx_count};

  assign result.valid = res_valid;
  assign result.read_data = holding_data;
  assign result.read_overrun = holding_overrun;
  assign result.rx_empty = rx_count == '0;
  assign result.rx_full = rx_count == CW'(SLOTS);
  assign result.tx_empty = tx_count == '0;
  assign result.tx_full = tx_count == TW'(FIFO_DEPTH);
  assign result.rx_level = rx_ext[LW-1:0];
  assign result.tx_level = tx_ext[LW-1:0];

endmodule

// ===== tb/uart_fifo_data_register_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the UART FIFO data register unit.
module uart_fifo_data_register_unit_tb;

  localparam int DEPTH = ufdr_pkg::DEFAULT_FIFO_DEPTH;
  localparam int SLOTS = DEPTH + 1;
  localparam int LVW = ufdr_pkg::LEVEL_W;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [7:0] data;
    logic overrun;
    logic rx_empty;
    logic rx_full;
    logic tx_empty;
    logic tx_full;
    logic [LVW-1:0] rx_level;
    logic [LVW-1:0] tx_level;
  } status_t;

  typedef struct packed {
    ufdr_pkg::action_t op;
    logic [7:0] data;
  } bus_op_t;

  logic clk;
  logic rst;

  ufdr_item_if item_ch ();
  ufdr_result_if result_ch ();
  ufdr_cfg_if cfg_ch ();

  uart_fifo_data_register_unit dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  bus_op_t bus_ops[$];
  status_t status_due[$];
  int errors = 0;
  bit calm = 1'b0;
  int hold_reqs = 0;

  // Shadow copy of the data register side.
  ufdr_pkg::entry_t rx_mem [SLOTS];
  int rx_head = 0;
  int rx_cnt = 0;
  int tx_cnt = 0;
  ufdr_pkg::entry_t hold_reg = '0;
  logic loopback = 1'b0;

  function automatic void rx_enqueue(logic [7:0] d);
    ufdr_pkg::entry_t e;
    if (rx_cnt >= SLOTS) return;
    e.overrun = (rx_cnt == DEPTH);
    e.data = d;
    rx_mem[(rx_head + rx_cnt) % SLOTS] = e;
    rx_cnt++;
  endfunction

  function automatic status_t data_reg_step(bus_op_t t);
    status_t s;
    case (t.op)
      ufdr_pkg::ACT_LINE_RX: rx_enqueue(t.data);
      ufdr_pkg::ACT_CPU_READ: begin
        if (rx_cnt > 0) begin
          hold_reg = rx_mem[rx_head];
          rx_head = (rx_head + 1) % SLOTS;
          rx_cnt--;
        end
      end
      ufdr_pkg::ACT_CPU_WRITE: begin
        if (loopback) rx_enqueue(t.data);
        else if (tx_cnt < DEPTH) tx_cnt++;
      end
      default: begin
        rx_head = 0;
        rx_cnt = 0;
        tx_cnt = 0;
      end
    endcase
    s.data = hold_reg.data;
    s.overrun = hold_reg.overrun;
    s.rx_empty = (rx_cnt == 0);
    s.rx_full = (rx_cnt == SLOTS);
    s.tx_empty = (tx_cnt == 0);
    s.tx_full = (tx_cnt == DEPTH);
    s.rx_level = LVW'(rx_cnt);
    s.tx_level = LVW'(tx_cnt);
    return s;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 5;
      default: return 25;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  int src_gap = 0;
  int src_pct = 10;
  int src_xfers = 0;

  always @(posedge clk) begin
    bus_op_t nxt;
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.action <= ufdr_pkg::ACT_LINE_RX;
      item_ch.data_byte <= 8'h00;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        nxt.op = ufdr_pkg::action_t'(item_ch.action);
        nxt.data = item_ch.data_byte;
        status_due.push_back(data_reg_step(nxt));
        src_xfers++;
        if (src_xfers % 64 == 0) src_pct = pick_idle_pct();
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          item_ch.valid <= 1'b0;
        end else if (!calm && src_pct > 0 && $urandom_range(99) < src_pct) begin
          src_gap = $urandom_range(0, 18);
          item_ch.valid <= 1'b0;
        end else if (bus_ops.size() > 0) begin
          nxt = bus_ops.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.action <= nxt.op;
          item_ch.data_byte <= nxt.data;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  int snk_stall = 0;
  int snk_pct = 10;
  int snk_xfers = 0;
  int hold_seen = 0;

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got.data = result_ch.read_data;
        got.overrun = result_ch.read_overrun;
        got.rx_empty = result_ch.rx_empty;
        got.rx_full = result_ch.rx_full;
        got.tx_empty = result_ch.tx_empty;
        got.tx_full = result_ch.tx_full;
        got.rx_level = result_ch.rx_level;
        got.tx_level = result_ch.tx_level;
        if (status_due.size() == 0) begin
          $error("unexpected result transfer: read_data %0h", got.data);
          errors++;
        end else begin
          want = status_due.pop_front();
          if (got.data !== want.data) begin
            $error("read_data: expected %0h, actual %0h", want.data, got.data);
            errors++;
          end
          if (got.overrun !== want.overrun) begin
            $error("read_overrun: expected %0b, actual %0b", want.overrun, got.overrun);
            errors++;
          end
          if (got.rx_empty !== want.rx_empty) begin
            $error("rx_empty: expected %0b, actual %0b", want.rx_empty, got.rx_empty);
            errors++;
          end
          if (got.rx_full !== want.rx_full) begin
            $error("rx_full: expected %0b, actual %0b", want.rx_full, got.rx_full);
            errors++;
          end
          if (got.tx_empty !== want.tx_empty) begin
            $error("tx_empty: expected %0b, actual %0b", want.tx_empty, got.tx_empty);
            errors++;
          end
          if (got.tx_full !== want.tx_full) begin
            $error("tx_full: expected %0b, actual %0b", want.tx_full, got.tx_full);
            errors++;
          end
          if (got.rx_level !== want.rx_level) begin
            $error("rx_level: expected %0d, actual %0d", want.rx_level, got.rx_level);
            errors++;
          end
          if (got.tx_level !== want.tx_level) begin
            $error("tx_level: expected %0d, actual %0d", want.tx_level, got.tx_level);
            errors++;
          end
        end
        snk_xfers++;
        if (snk_xfers % 64 == 0) snk_pct = pick_idle_pct();
      end
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        snk_stall = LONG_HOLD - 1;
        result_ch.ready <= 1'b0;
      end else if (snk_stall > 0) begin
        snk_stall--;
        result_ch.ready <= 1'b0;
      end else if (!calm && snk_pct > 0 && $urandom_range(99) < snk_pct) begin
        snk_stall = $urandom_range(0, 18);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("uart_fifo_data_register_unit_tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic add_op(input ufdr_pkg::action_t op, input logic [7:0] d);
    bus_op_t t;
    t.op = op;
    t.data = d;
    bus_ops.push_back(t);
  endtask

  task automatic drain();
    while (bus_ops.size() > 0 || status_due.size() > 0 || item_ch.valid) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_loopback(input logic v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.loopback_enable <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    loopback = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // Fill bursts push line bytes or CPU writes toward full; drain bursts read the receive side back out.
  task automatic queue_random(input int n);
    int added;
    int len;
    int kind;
    int r;
    ufdr_pkg::action_t op;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(9);
      if (kind <= 2) begin
        len = $urandom_range(20, 40);
        r = $urandom_range(2);
        for (int i = 0; i < len; i++) begin
          if (r == 0) op = ufdr_pkg::ACT_LINE_RX;
          else if (r == 1) op = ufdr_pkg::ACT_CPU_WRITE;
          else op = $urandom_range(1) ? ufdr_pkg::ACT_LINE_RX : ufdr_pkg::ACT_CPU_WRITE;
          add_op(op, 8'($urandom_range(255)));
        end
      end else if (kind <= 4) begin
        len = $urandom_range(10, 40);
        for (int i = 0; i < len; i++) begin
          add_op(ufdr_pkg::ACT_CPU_READ, 8'($urandom_range(255)));
        end
      end else if (kind <= 8) begin
        len = $urandom_range(10, 30);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(99);
          if (r < 35) op = ufdr_pkg::ACT_LINE_RX;
          else if (r < 70) op = ufdr_pkg::ACT_CPU_READ;
          else if (r < 95) op = ufdr_pkg::ACT_CPU_WRITE;
          else op = ufdr_pkg::ACT_FLUSH;
          add_op(op, 8'($urandom_range(255)));
        end
      end else begin
        len = 1;
        add_op(ufdr_pkg::ACT_FLUSH, 8'($urandom_range(255)));
      end
      added += len;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.loopback_enable <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_loopback(1'b0);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    add_op(ufdr_pkg::ACT_LINE_RX, 8'h00);
    add_op(ufdr_pkg::ACT_LINE_RX, 8'hFF);
    add_op(ufdr_pkg::ACT_LINE_RX, 8'h80);
    add_op(ufdr_pkg::ACT_LINE_RX, 8'h01);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'hFF);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    add_op(ufdr_pkg::ACT_CPU_WRITE, 8'hAA);
    add_op(ufdr_pkg::ACT_CPU_WRITE, 8'h55);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    add_op(ufdr_pkg::ACT_FLUSH, 8'hFF);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    add_op(ufdr_pkg::ACT_LINE_RX, 8'h7F);
    add_op(ufdr_pkg::ACT_FLUSH, 8'h00);
    add_op(ufdr_pkg::ACT_CPU_WRITE, 8'h00);
    drain();

    set_loopback(1'b1);
    add_op(ufdr_pkg::ACT_CPU_WRITE, 8'hC3);
    add_op(ufdr_pkg::ACT_LINE_RX, 8'h3C);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    add_op(ufdr_pkg::ACT_CPU_WRITE, 8'hFF);
    add_op(ufdr_pkg::ACT_FLUSH, 8'h00);
    add_op(ufdr_pkg::ACT_CPU_READ, 8'h00);
    queue_random(450);
    while (bus_ops.size() > 300) @(posedge clk);
    hold_reqs++;
    drain();

    set_loopback(1'b0);
    queue_random(500);
    while (bus_ops.size() > 300) @(posedge clk);
    hold_reqs++;
    drain();

    set_loopback(1'b1);
    queue_random(350);
    drain();

    set_loopback(1'b0);
    calm = 1'b1;
    queue_random(350);
    drain();

    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("uart_fifo_data_register_unit_tb: done, clean");
    end else begin
      $display("uart_fifo_data_register_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
